[design/flh_pkg.sv]
`timescale 1ns / 1ps

package flh_pkg;

    localparam int OUT_BITS  = 32;
    localparam int NUM_BASES = 6;

    // Text codes
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_G        = 8'h47;
    localparam logic [7:0] CH_T        = 8'h54;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] KEEP_LO     = 8'd65;
    localparam logic [7:0] KEEP_HI     = 8'd122;

    localparam logic [15:0] BIN_WIDTH_RESET = 16'd100;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_END    = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_SEEK   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_SEQ    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        BASE_A     = 3'd0,
        BASE_C     = 3'd1,
        BASE_G     = 3'd2,
        BASE_T     = 3'd3,
        BASE_N     = 3'd4,
        BASE_OTHER = 3'd5
    } base_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] seq_count;
        logic [OUT_BITS-1:0] max_len;
        logic [OUT_BITS-1:0] total_len;
        logic [OUT_BITS-1:0] count_a;
        logic [OUT_BITS-1:0] count_c;
        logic [OUT_BITS-1:0] count_g;
        logic [OUT_BITS-1:0] count_t;
        logic [OUT_BITS-1:0] count_n;
        logic [OUT_BITS-1:0] count_other;
        logic [OUT_BITS-1:0] bin_count;
    } result_t;

endpackage

[design/fasta_length_histogram.sv]
`timescale 1ns / 1ps

// FASTA length histogram: takes one word per cycle while in_ready is high (cmd, data_byte,
// bin_index) and returns one result word for each end-of-input or report command. Text
// bytes and record closes are absorbed at one word per clock while in_ready is high; a
// record close does a read-modify-write of one bin in the histogram RAM (one write port,
// two registered read ports), and a one-deep write-forwarding register covers reads of the
// bin written by the last close. Results sit in a two-word output queue, so in_ready stays
// high while a result waits unless the queue would overflow. After reset the block zeroes
// the histogram, one bin per cycle, with in_ready low; cfg_we writes are taken at any time.
module fasta_length_histogram #(
    parameter int HIST_BINS    = 4096,
    parameter int COUNTER_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [11:0] bin_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] seq_count,
    output logic [31:0] max_len,
    output logic [31:0] total_len,
    output logic [31:0] count_a,
    output logic [31:0] count_c,
    output logic [31:0] count_g,
    output logic [31:0] count_t,
    output logic [31:0] count_n,
    output logic [31:0] count_other,
    output logic [31:0] bin_count
);

    localparam int              AW      = $clog2(HIST_BINS);
    localparam int              CW      = COUNTER_BITS;
    localparam logic [CW-1:0]   CNT_MAX = {CW{1'b1}};
    localparam logic [AW-1:0]   LAST_BIN = AW'(HIST_BINS - 1);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
        return (a == CNT_MAX) ? CNT_MAX : a + 1'b1;
    endfunction

    // Configuration and parse state
    logic [15:0]            bin_width_reg;
    flh_pkg::mode_t         mode_reg, mode_next;
    logic [CW-1:0]          len_reg, len_next;
    logic [15:0]            within_reg, within_next;
    logic [AW-1:0]          cur_bin_reg, cur_bin_next;
    logic [CW-1:0]          seq_reg, seq_next;
    logic [CW-1:0]          longest_reg, longest_next;
    logic [CW-1:0]          sum_reg, sum_next;
    logic [CW-1:0]          base_reg [flh_pkg::NUM_BASES];
    logic [CW-1:0]          base_next [flh_pkg::NUM_BASES];

    // Clearing sweep
    logic                   clearing_reg;
    logic [AW-1:0]          clear_addr_reg;

    // Stage 1
    logic                   s1_inc_reg;
    logic [AW-1:0]          s1_inc_addr_reg;
    logic                   s1_rep_reg;
    logic [AW-1:0]          s1_rep_addr_reg;
    logic                   s1_in_range_reg;
    flh_pkg::result_t       s1_res_reg;

    // Last histogram write
    logic                   lw_valid_reg;
    logic [AW-1:0]          lw_addr_reg;
    logic [CW-1:0]          lw_data_reg;

    // Output queue
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    flh_pkg::result_t       out_data_reg, skid_data_reg;
    logic                   out_load, out_from_skid, skid_load;

    logic                   accept;
    logic                   pop;
    logic [1:0]             queue_use;
    flh_pkg::cmd_t          cmd_code;
    logic [7:0]             upper;
    logic                   kept;
    logic [2:0]             base_cls;
    logic [15:0]            bw;
    logic [16:0]            within_inc;
    logic [CW:0]            sum_wide;
    logic                   do_close, do_clear, close_hit, rep_hit;
    logic                   in_range;
    flh_pkg::result_t       snap;

    logic [CW-1:0]          rdata_a, rdata_b;
    logic [CW-1:0]          a_data, b_data, inc_data, bin_val;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [CW-1:0]          ram_wdata;
    flh_pkg::result_t       s1_result;

    assign pop       = out_valid_reg && out_ready;
    assign queue_use = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(s1_rep_reg) - 2'(pop);
    assign in_ready  = !clearing_reg && (queue_use <= 2'd1);
    assign accept    = in_valid && in_ready;
    assign cmd_code  = flh_pkg::cmd_t'(cmd);

    assign bw       = (bin_width_reg == 16'd0) ? 16'd1 : bin_width_reg;
    assign upper    = (data_byte >= flh_pkg::CH_LOW_A && data_byte <= flh_pkg::CH_LOW_Z) ?
                      data_byte - flh_pkg::CASE_OFFSET : data_byte;
    assign kept     = (data_byte >= flh_pkg::KEEP_LO) && (data_byte <= flh_pkg::KEEP_HI);
    assign in_range = 32'(bin_index) < 32'(HIST_BINS);

    always_comb
    begin
        case (upper)
            flh_pkg::CH_A: base_cls = flh_pkg::BASE_A;
            flh_pkg::CH_C: base_cls = flh_pkg::BASE_C;
            flh_pkg::CH_G: base_cls = flh_pkg::BASE_G;
            flh_pkg::CH_T: base_cls = flh_pkg::BASE_T;
            flh_pkg::CH_N: base_cls = flh_pkg::BASE_N;
            default:       base_cls = flh_pkg::BASE_OTHER;
        endcase
    end

    assign within_inc = {1'b0, within_reg} + 17'd1;
    assign sum_wide   = {1'b0, sum_reg} + {1'b0, len_reg};

    // Parser and counters: next state and outputs
    always_comb
    begin
        mode_next    = mode_reg;
        len_next     = len_reg;
        within_next  = within_reg;
        cur_bin_next = cur_bin_reg;
        seq_next     = seq_reg;
        longest_next = longest_reg;
        sum_next     = sum_reg;
        for (int j = 0; j < flh_pkg::NUM_BASES; j++)
        begin
            base_next[j] = base_reg[j];
        end
        do_close  = 1'b0;
        do_clear  = 1'b0;
        close_hit = 1'b0;
        rep_hit   = 1'b0;

        if (accept)
        begin
            unique case (cmd_code)
                flh_pkg::CMD_BYTE:
                begin
                    unique case (mode_reg)
                        flh_pkg::MODE_SEEK:
                        begin
                            if (data_byte == flh_pkg::CH_GT)
                            begin
                                mode_next = flh_pkg::MODE_HEADER;
                            end
                        end
                        flh_pkg::MODE_HEADER:
                        begin
                            if (data_byte == flh_pkg::CH_LF)
                            begin
                                mode_next = flh_pkg::MODE_SEQ;
                            end
                        end
                        flh_pkg::MODE_SEQ:
                        begin
                            if (data_byte == flh_pkg::CH_GT)
                            begin
                                do_close  = 1'b1;
                                do_clear  = 1'b1;
                                mode_next = flh_pkg::MODE_HEADER;
                            end
                            else if (kept)
                            begin
                                for (int j = 0; j < flh_pkg::NUM_BASES; j++)
                                begin
                                    if (base_cls == 3'(j))
                                    begin
                                        base_next[j] = sat_inc(base_reg[j]);
                                    end
                                end
                                if (len_reg != CNT_MAX)
                                begin
                                    len_next = len_reg + 1'b1;
                                    if (within_inc >= {1'b0, bw})
                                    begin
                                        within_next = 16'd0;
                                        if (cur_bin_reg < LAST_BIN)
                                        begin
                                            cur_bin_next = cur_bin_reg + 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        within_next = within_inc[15:0];
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            mode_next = flh_pkg::MODE_SEEK;
                        end
                    endcase
                end
                flh_pkg::CMD_END:
                begin
                    do_close  = (mode_reg == flh_pkg::MODE_SEQ);
                    do_clear  = 1'b1;
                    mode_next = flh_pkg::MODE_SEEK;
                    rep_hit   = 1'b1;
                end
                flh_pkg::CMD_REPORT:
                begin
                    rep_hit = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Drop empty records
        if (do_close && len_reg != '0)
        begin
            close_hit    = 1'b1;
            seq_next     = sat_inc(seq_reg);
            sum_next     = (sum_wide >= {1'b0, CNT_MAX}) ? CNT_MAX : sum_wide[CW-1:0];
            longest_next = (len_reg > longest_reg) ? len_reg : longest_reg;
        end
        if (do_clear)
        begin
            len_next     = '0;
            within_next  = 16'd0;
            cur_bin_next = '0;
        end
    end

    always_comb
    begin
        snap             = '0;
        snap.seq_count   = 32'(seq_next);
        snap.max_len     = 32'(longest_next);
        snap.total_len   = 32'(sum_next);
        snap.count_a     = 32'(base_reg[flh_pkg::BASE_A]);
        snap.count_c     = 32'(base_reg[flh_pkg::BASE_C]);
        snap.count_g     = 32'(base_reg[flh_pkg::BASE_G]);
        snap.count_t     = 32'(base_reg[flh_pkg::BASE_T]);
        snap.count_n     = 32'(base_reg[flh_pkg::BASE_N]);
        snap.count_other = 32'(base_reg[flh_pkg::BASE_OTHER]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= flh_pkg::BIN_WIDTH_RESET;
            mode_reg      <= flh_pkg::MODE_SEEK;
            len_reg       <= '0;
            within_reg    <= 16'd0;
            cur_bin_reg   <= '0;
            seq_reg       <= '0;
            longest_reg   <= '0;
            sum_reg       <= '0;
            for (int j = 0; j < flh_pkg::NUM_BASES; j++)
            begin
                base_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                bin_width_reg <= cfg_data;
            end
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            within_reg  <= within_next;
            cur_bin_reg <= cur_bin_next;
            seq_reg     <= seq_next;
            longest_reg <= longest_next;
            sum_reg     <= sum_next;
            for (int j = 0; j < flh_pkg::NUM_BASES; j++)
            begin
                base_reg[j] <= base_next[j];
            end
        end
    end

    // Zero the histogram after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_BIN)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    flh_ram #(
        .WIDTH (CW),
        .DEPTH (HIST_BINS)
    ) u_hist (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (cur_bin_reg),
        .rdata_a (rdata_a),
        .raddr_b (AW'(bin_index)),
        .rdata_b (rdata_b)
    );

    // Stage 1: finish the bin increment and pick up the reported bin
    assign a_data   = (lw_valid_reg && lw_addr_reg == s1_inc_addr_reg) ? lw_data_reg : rdata_a;
    assign b_data   = (lw_valid_reg && lw_addr_reg == s1_rep_addr_reg) ? lw_data_reg : rdata_b;
    assign inc_data = sat_inc(a_data);

    always_comb
    begin
        if (!s1_in_range_reg)
        begin
            bin_val = '0;
        end
        else if (s1_inc_reg && s1_inc_addr_reg == s1_rep_addr_reg)
        begin
            bin_val = inc_data;
        end
        else
        begin
            bin_val = b_data;
        end
        s1_result           = s1_res_reg;
        s1_result.bin_count = 32'(bin_val);
    end

    assign ram_we    = clearing_reg || s1_inc_reg;
    assign ram_waddr = clearing_reg ? clear_addr_reg : s1_inc_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : inc_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_inc_reg   <= 1'b0;
            s1_rep_reg   <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            s1_inc_reg   <= close_hit;
            s1_rep_reg   <= rep_hit;
            lw_valid_reg <= s1_inc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_hit)
        begin
            s1_inc_addr_reg <= cur_bin_reg;
        end
        if (rep_hit)
        begin
            s1_rep_addr_reg <= AW'(bin_index);
            s1_in_range_reg <= in_range;
            s1_res_reg      <= snap;
        end
        if (s1_inc_reg)
        begin
            lw_addr_reg <= s1_inc_addr_reg;
            lw_data_reg <= inc_data;
        end
    end

    // Two-word output queue: head register and skid
    always_comb
    begin
        out_load      = 1'b0;
        out_from_skid = 1'b0;
        skid_load     = 1'b0;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_load        = 1'b1;
                out_from_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_load       = s1_rep_reg;
                skid_valid_next = s1_rep_reg;
            end
            else
            begin
                out_load        = s1_rep_reg;
                out_valid_next  = s1_rep_reg;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            out_valid_next  = 1'b1;
            skid_load       = s1_rep_reg;
            skid_valid_next = skid_valid_reg || s1_rep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_from_skid ? skid_data_reg : s1_result;
        end
        if (skid_load)
        begin
            skid_data_reg <= s1_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign seq_count   = out_data_reg.seq_count;
    assign max_len     = out_data_reg.max_len;
    assign total_len   = out_data_reg.total_len;
    assign count_a     = out_data_reg.count_a;
    assign count_c     = out_data_reg.count_c;
    assign count_g     = out_data_reg.count_g;
    assign count_t     = out_data_reg.count_t;
    assign count_n     = out_data_reg.count_n;
    assign count_other = out_data_reg.count_other;
    assign bin_count   = out_data_reg.bin_count;

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty head");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_rep_reg && out_valid_reg && !out_ready) |-> !skid_valid_reg)
        else $error("output queue overflow");

    a_no_inc_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_inc_reg && !s1_rep_reg && !lw_valid_reg))
        else $error("histogram access during clearing sweep");

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_bin_reg <= LAST_BIN)
        else $error("running bin beyond last bin");

    a_inc_follows_close: assert property (@(posedge clk) disable iff (!rst_n)
        s1_inc_reg |=> (lw_valid_reg && lw_addr_reg == $past(s1_inc_addr_reg)))
        else $error("forwarding register missed a bin write");
`endif

endmodule

[design/flh_ram.sv]
`timescale 1ns / 1ps

module flh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the contents before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int          HIST_DEPTH   = 4096;
    localparam int          WATCH_LIMIT  = 20000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 6;
    localparam int          PHASE_WORDS  = 230;
    localparam int          LONG_RECORD  = 160;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [7:0]  BASE_CHARS [5] = '{flh_pkg::CH_A, flh_pkg::CH_C, flh_pkg::CH_G,
                                              flh_pkg::CH_T, flh_pkg::CH_N};

    typedef enum int { CLOSE_NONE, CLOSE_REPORT, CLOSE_END } rec_close_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       chr;
        logic [11:0]      bin;
        logic             fixed;
        flh_pkg::result_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd         = '0;
    logic [7:0]  data_byte   = '0;
    logic [11:0] bin_index   = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] seq_count, max_len, total_len;
    logic [31:0] count_a, count_c, count_g, count_t, count_n, count_other, bin_count;

    fasta_length_histogram #(
        .HIST_BINS    (HIST_DEPTH),
        .COUNTER_BITS (32)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .bin_index   (bin_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .seq_count   (seq_count),
        .max_len     (max_len),
        .total_len   (total_len),
        .count_a     (count_a),
        .count_c     (count_c),
        .count_g     (count_g),
        .count_t     (count_t),
        .count_n     (count_n),
        .count_other (count_other),
        .bin_count   (bin_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Histogram predictor state
    flh_pkg::mode_t parse_now;
    logic [15:0] width_now;
    logic [31:0] open_len;
    int unsigned bin_fill;
    logic [11:0] open_bin;
    logic [31:0] rec_count;
    logic [31:0] longest_len;
    logic [31:0] len_sum;
    logic [31:0] base_tally [flh_pkg::NUM_BASES];
    logic [31:0] hist_model [HIST_DEPTH];

    flh_pkg::result_t pending_reports [$];
    int unsigned faults        = 0;
    int unsigned sent_words    = 0;
    int unsigned sender_idle   = 11;
    int unsigned recv_idle     = 60;
    int unsigned stall_asks    = 0;

    string field_names [10] = '{"seq_count", "max_len", "total_len", "count_a", "count_c",
                                "count_g", "count_t", "count_n", "count_other", "bin_count"};

    script_row_t opening_script [25] = '{
        '{flh_pkg::CMD_REPORT, 8'h00,                         12'd0,    1'b1, '0},
        '{flh_pkg::CMD_BYTE,   8'hFF,                         12'd0,    1'b0, '0},
        '{flh_pkg::CMD_END,    8'h00,                         12'd4095, 1'b1, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_GT,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_GT,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_LOW_A,             12'd0,    1'b0, '0},
        '{flh_pkg::CMD_END,    8'h00,                         12'd0,    1'b1, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_GT,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_LF,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_LOW_A,             12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_C,                 12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_G + flh_pkg::CASE_OFFSET,
          12'd0, 1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_T,                 12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_N + flh_pkg::CASE_OFFSET,
          12'd0, 1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_LOW_Z,             12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::KEEP_LO - 8'd1,       12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::KEEP_HI + 8'd1,       12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   8'hFF,                         12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   8'h5B,                         12'd0,    1'b0, '0},
        '{CMD_UNUSED,          8'h00,                         12'd4095, 1'b0, '0},
        '{flh_pkg::CMD_REPORT, 8'h00,                         12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_GT,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_LF,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_BYTE,   flh_pkg::CH_GT,                12'd0,    1'b0, '0},
        '{flh_pkg::CMD_END,    8'h00,                         12'd0,    1'b0, '0}
    };

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function void clear_record();
        open_len = '0;
        bin_fill = 0;
        open_bin = '0;
    endfunction

    function void close_record();
        if (open_len != '0)
        begin
            rec_count = sat_add32(rec_count, 32'd1);
            len_sum   = sat_add32(len_sum, open_len);
            if (open_len > longest_len)
                longest_len = open_len;
            hist_model[open_bin] = sat_add32(hist_model[open_bin], 32'd1);
        end
        clear_record();
    endfunction

    function void reset_histogram_model();
        parse_now   = flh_pkg::MODE_SEEK;
        width_now   = flh_pkg::BIN_WIDTH_RESET;
        rec_count   = '0;
        longest_len = '0;
        len_sum     = '0;
        clear_record();
        foreach (base_tally[i])
            base_tally[i] = '0;
        foreach (hist_model[i])
            hist_model[i] = '0;
    endfunction

    // Advance the predictor by one word; return 1 when the word yields a report
    function automatic bit tally_word(input logic [1:0] op, input logic [7:0] chr,
                                      input logic [11:0] bin, output flh_pkg::result_t rep);
        logic [7:0]     c;
        flh_pkg::base_t cls;
        int unsigned    span;
        rep = '0;
        if (op == flh_pkg::CMD_BYTE)
        begin
            c = chr;
            if (parse_now == flh_pkg::MODE_SEEK)
            begin
                if (c == flh_pkg::CH_GT)
                    parse_now = flh_pkg::MODE_HEADER;
            end
            else if (parse_now == flh_pkg::MODE_HEADER)
            begin
                if (c == flh_pkg::CH_LF)
                    parse_now = flh_pkg::MODE_SEQ;
            end
            else if (c == flh_pkg::CH_GT)
            begin
                close_record();
                parse_now = flh_pkg::MODE_HEADER;
            end
            else
            begin
                if (c >= flh_pkg::CH_LOW_A && c <= flh_pkg::CH_LOW_Z)
                    c = c - flh_pkg::CASE_OFFSET;
                if (c >= flh_pkg::KEEP_LO && c <= flh_pkg::KEEP_HI)
                begin
                    case (c)
                        flh_pkg::CH_A: cls = flh_pkg::BASE_A;
                        flh_pkg::CH_C: cls = flh_pkg::BASE_C;
                        flh_pkg::CH_G: cls = flh_pkg::BASE_G;
                        flh_pkg::CH_T: cls = flh_pkg::BASE_T;
                        flh_pkg::CH_N: cls = flh_pkg::BASE_N;
                        default:       cls = flh_pkg::BASE_OTHER;
                    endcase
                    base_tally[cls] = sat_add32(base_tally[cls], 32'd1);
                    span = (width_now == '0) ? 1 : width_now;
                    if (open_len != '1)
                    begin
                        open_len = open_len + 32'd1;
                        bin_fill++;
                        // compare against the width in force now, even mid-record
                        if (bin_fill >= span)
                        begin
                            bin_fill = 0;
                            if (open_bin != 12'(HIST_DEPTH - 1))
                                open_bin = open_bin + 12'd1;
                        end
                    end
                end
            end
            return 1'b0;
        end
        if (op != flh_pkg::CMD_END && op != flh_pkg::CMD_REPORT)
            return 1'b0;
        if (op == flh_pkg::CMD_END)
        begin
            if (parse_now == flh_pkg::MODE_SEQ)
                close_record();
            else
                clear_record();
            parse_now = flh_pkg::MODE_SEEK;
        end
        rep = {rec_count, longest_len, len_sum,
               base_tally[flh_pkg::BASE_A], base_tally[flh_pkg::BASE_C],
               base_tally[flh_pkg::BASE_G], base_tally[flh_pkg::BASE_T],
               base_tally[flh_pkg::BASE_N], base_tally[flh_pkg::BASE_OTHER],
               hist_model[bin]};
        return 1'b1;
    endfunction

    function void report_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%s", msg);
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [7:0] chr, input logic [11:0] bin,
                             input bit fixed = 1'b0, input flh_pkg::result_t want = '0);
        flh_pkg::result_t rep;
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        data_byte <= chr;
        bin_index <= bin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tally_word(op, chr, bin, rep))
            pending_reports.push_back(fixed ? want : rep);
        if (op != CMD_UNUSED)
            sent_words++;
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_width(input logic [15:0] w);
        drain_reports();
        // let the last record close settle before touching the width
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_now = w;
    endtask

    function automatic logic [11:0] pick_bin();
        return ($urandom_range(99) < 25) ? 12'($urandom_range(4095)) : 12'($urandom_range(127));
    endfunction

    task automatic send_record(input int unsigned len, input rec_close_t how,
                               input logic [11:0] bin);
        logic [7:0]  c;
        int unsigned r;
        send_word(flh_pkg::CMD_BYTE, flh_pkg::CH_GT, '0);
        repeat ($urandom_range(6))
        begin
            c = 8'($urandom_range(255));
            send_word(flh_pkg::CMD_BYTE, (c == flh_pkg::CH_LF) ? flh_pkg::CH_LOW_A : c, '0);
        end
        // occasionally drop the header newline so bases fall into the header
        if ($urandom_range(99) >= 5)
            send_word(flh_pkg::CMD_BYTE, flh_pkg::CH_LF, '0);
        repeat (len)
        begin
            r = $urandom_range(99);
            if (r < 75)
            begin
                c = BASE_CHARS[$urandom_range(4)];
                if ($urandom_range(1) == 1)
                    c = c + flh_pkg::CASE_OFFSET;
            end
            else if (r < 85)
                c = 8'($urandom_range(flh_pkg::KEEP_HI, flh_pkg::KEEP_LO));
            else if (r < 93)
                c = flh_pkg::CH_LF;
            else
            begin
                c = 8'($urandom_range(255));
                if (c == flh_pkg::CH_GT)
                    c = flh_pkg::CH_LF;
            end
            send_word(flh_pkg::CMD_BYTE, c, '0);
        end
        if (how == CLOSE_REPORT)
            send_word(flh_pkg::CMD_REPORT, 8'($urandom_range(255)), bin);
        else if (how == CLOSE_END)
            send_word(flh_pkg::CMD_END, 8'($urandom_range(255)), bin);
    endtask

    // Receiver: random back-pressure plus one long hold on request
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned asks_seen;
        hold_left = 0;
        asks_seen = 0;
        forever
        begin
            @(posedge clk);
            if (stall_asks != asks_seen)
            begin
                asks_seen = stall_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin : check_reports
        flh_pkg::result_t got;
        flh_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {seq_count, max_len, total_len, count_a, count_c, count_g,
                   count_t, count_n, count_other, bin_count};
            if (pending_reports.size() == 0)
                report_fault($sformatf("unexpected report: %h", got));
            else
            begin
                want = pending_reports.pop_front();
                for (int k = 0; k < 10; k++)
                    if (got[(9 - k) * 32 +: 32] != want[(9 - k) * 32 +: 32])
                        report_fault($sformatf("%s mismatch: expected %0d, got %0d",
                                               field_names[k], want[(9 - k) * 32 +: 32],
                                               got[(9 - k) * 32 +: 32]));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCH_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] widths [6];
        int unsigned phase_end;
        int unsigned r;
        int unsigned len;
        rec_close_t  how;
        widths = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd2, 16'd100};
        reset_histogram_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_script[i])
            send_word(opening_script[i].op, opening_script[i].chr, opening_script[i].bin,
                      opening_script[i].fixed, opening_script[i].want);

        for (int phase = 0; phase < 6; phase++)
        begin
            sender_idle = (phase < 2) ? 11 : (phase < 4) ? 60 : 0;
            recv_idle   = (phase < 2) ? 60 : (phase < 4) ? 11 : 0;
            // records may stay open across the width change
            write_width(widths[phase]);
            if (phase == 0)
            begin
                // one long record spread over many narrow bins
                send_record(LONG_RECORD, CLOSE_END, 12'(HIST_DEPTH - 1));
                send_word(flh_pkg::CMD_REPORT, 8'h00, 12'(HIST_DEPTH - 2));
                stall_asks++;
            end
            phase_end = sent_words + PHASE_WORDS;
            while (sent_words < phase_end)
            begin
                r = $urandom_range(99);
                if (r < 6)
                    send_word(2'($urandom_range(3)), 8'($urandom_range(255)),
                              12'($urandom_range(4095)));
                else if (r < 9)
                    drain_reports();
                else
                begin
                    r   = $urandom_range(99);
                    len = (r < 10) ? 0 : (r < 90) ? $urandom_range(24, 1)
                                                  : $urandom_range(120, 25);
                    r   = $urandom_range(99);
                    how = (r < 45) ? CLOSE_REPORT : (r < 65) ? CLOSE_END : CLOSE_NONE;
                    send_record(len, how, pick_bin());
                end
            end
        end

        drain_reports();
        repeat (SETTLE * 4) @(posedge clk);
        while (pending_reports.size() != 0)
        begin
            void'(pending_reports.pop_front());
            report_fault("report never arrived");
        end
        if (faults == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[sim.f]
design/flh_pkg.sv
design/flh_ram.sv
design/fasta_length_histogram.sv
tb/testbench.sv
